FILE: hdl/dfdh_pkg.sv
// ============================================================================
// dfdh_pkg
// Shared types, constants and quantizer functions for the distance filter.
// ============================================================================
package dfdh_pkg;

    // Lane storage
    localparam int LANE_COUNT = 4;
    localparam int LANE_AW    = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

    // Field widths
    localparam int LANE_W  = 2;
    localparam int DIST_W  = 16;
    localparam int ALPHA_W = 9;
    localparam int LIMIT_W = 8;
    localparam int COUNT_W = 8;
    localparam int LEVEL_W = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_Q8      = 2'd0,
        CFG_INVALID_LIMIT = 2'd1
    } t_cfg_index;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd77;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;

    // Density levels
    localparam logic [LEVEL_W-1:0] LEVEL_0  = 4'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_2  = 4'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_4  = 4'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_6  = 4'd6;
    localparam logic [LEVEL_W-1:0] LEVEL_8  = 4'd8;
    localparam logic [LEVEL_W-1:0] LEVEL_10 = 4'd10;

    // Direct quantizer bounds, 1/16 cm
    localparam logic [DIST_W-1:0] DIRECT_10 = 16'd160;
    localparam logic [DIST_W-1:0] DIRECT_8  = 16'd320;
    localparam logic [DIST_W-1:0] DIRECT_6  = 16'd480;
    localparam logic [DIST_W-1:0] DIRECT_4  = 16'd640;
    localparam logic [DIST_W-1:0] DIRECT_2  = 16'd960;

    // Hysteresis bounds, 1/16 cm
    localparam logic [DIST_W-1:0] HYST_10_DOWN = 16'd184;
    localparam logic [DIST_W-1:0] HYST_8_UP    = 16'd144;
    localparam logic [DIST_W-1:0] HYST_8_DOWN  = 16'd336;
    localparam logic [DIST_W-1:0] HYST_6_UP    = 16'd304;
    localparam logic [DIST_W-1:0] HYST_6_DOWN  = 16'd496;
    localparam logic [DIST_W-1:0] HYST_4_UP    = 16'd464;
    localparam logic [DIST_W-1:0] HYST_4_DOWN  = 16'd656;
    localparam logic [DIST_W-1:0] HYST_2_UP    = 16'd624;
    localparam logic [DIST_W-1:0] HYST_2_DOWN  = 16'd976;

    typedef struct packed {
        logic [LANE_W-1:0] lane_index;
        logic [DIST_W-1:0] raw_distance;
        logic              raw_ok;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0]  smoothed_distance;
        logic               smoothed_ok;
        logic [LEVEL_W-1:0] density;
    } t_out_item;

    typedef struct packed {
        logic [DIST_W-1:0]  filtered;
        logic               initialized;
        logic [COUNT_W-1:0] bad_count;
        logic [LEVEL_W-1:0] level;
    } t_lane_state;

    function automatic logic [LEVEL_W-1:0] quantize_direct(input logic [DIST_W-1:0] d);
        logic [LEVEL_W-1:0] lv;
        if (d <= DIRECT_10)     lv = LEVEL_10;
        else if (d <= DIRECT_8) lv = LEVEL_8;
        else if (d <= DIRECT_6) lv = LEVEL_6;
        else if (d <= DIRECT_4) lv = LEVEL_4;
        else if (d <= DIRECT_2) lv = LEVEL_2;
        else                    lv = LEVEL_0;
        return lv;
    endfunction

    function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] level,
                                                      input logic [DIST_W-1:0]  d);
        logic [LEVEL_W-1:0] lv;
        unique case (level)
            LEVEL_10: begin
                lv = (d > HYST_10_DOWN) ? LEVEL_8 : LEVEL_10;
            end
            LEVEL_8: begin
                if (d <= HYST_8_UP)        lv = LEVEL_10;
                else if (d > HYST_8_DOWN)  lv = LEVEL_6;
                else                       lv = LEVEL_8;
            end
            LEVEL_6: begin
                if (d <= HYST_6_UP)        lv = LEVEL_8;
                else if (d > HYST_6_DOWN)  lv = LEVEL_4;
                else                       lv = LEVEL_6;
            end
            LEVEL_4: begin
                if (d <= HYST_4_UP)        lv = LEVEL_6;
                else if (d > HYST_4_DOWN)  lv = LEVEL_2;
                else                       lv = LEVEL_4;
            end
            LEVEL_2: begin
                if (d <= HYST_2_UP)        lv = LEVEL_4;
                else if (d > HYST_2_DOWN)  lv = LEVEL_0;
                else                       lv = LEVEL_2;
            end
            default: begin
                lv = quantize_direct(d);
            end
        endcase
        return lv;
    endfunction

endpackage

FILE: hdl/dfdh_lane_ram.sv
// ============================================================================
// dfdh_lane_ram
// Per-lane state memory: registered read, one write port, entry valid bits
// and forwarding of the most recent write.
// ============================================================================
module dfdh_lane_ram
    import dfdh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [LANE_AW-1:0] i_rd_addr,
    input  logic               i_wr_en,
    input  logic [LANE_AW-1:0] i_wr_addr,
    input  t_lane_state        i_wr_data,
    output t_lane_state        o_rd_data
);

    t_lane_state             r_mem [LANE_COUNT];
    logic [LANE_COUNT-1:0]   r_ent_valid;
    t_lane_state             r_rd_raw;
    logic                    r_rd_valid;
    logic [LANE_AW-1:0]      r_rd_addr;
    t_lane_state             r_lw_data;
    logic [LANE_AW-1:0]      r_lw_addr;
    logic                    r_lw_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw  <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
        if (i_wr_en) begin
            r_lw_data <= i_wr_data;
            r_lw_addr <= i_wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_rd_valid  <= 1'b0;
            r_lw_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ent_valid[i_wr_addr] <= 1'b1;
                r_lw_valid             <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_ent_valid[i_rd_addr];
            end
        end
    end

    // The last write is always the newest copy of its lane
    always_comb begin
        if (r_lw_valid && (r_lw_addr == r_rd_addr)) begin
            o_rd_data = r_lw_data;
        end else if (r_rd_valid) begin
            o_rd_data = r_rd_raw;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

FILE: hdl/dfdh_update.sv
// ============================================================================
// dfdh_update
// Lane state update: invalid-reading count, filter blend and hysteresis
// quantizer.
// ============================================================================
module dfdh_update
    import dfdh_pkg::*;
(
    input  t_lane_state        i_state,
    input  t_in_item           i_item,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_lane_state        o_state,
    output t_out_item          o_result
);

    logic [ALPHA_W-1:0]  alpha_sat;
    logic signed [16:0]  diff;
    logic signed [26:0]  prod;
    logic signed [26:0]  acc;
    logic [DIST_W-1:0]   blend;
    logic [COUNT_W-1:0]  bad_inc;
    logic                ok_out;
    logic [DIST_W-1:0]   out_dist;

    // new = (256*old + a*(raw-old) + 128) >> 8
    assign alpha_sat = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
    assign diff  = $signed({1'b0, i_item.raw_distance}) - $signed({1'b0, i_state.filtered});
    assign prod  = $signed({1'b0, alpha_sat}) * diff;
    assign acc   = $signed({3'b000, i_state.filtered, 8'h00}) + prod + 27'sd128;
    assign blend = acc[23:8];

    assign bad_inc = (i_state.bad_count == COUNT_MAX) ? COUNT_MAX
                                                      : i_state.bad_count + 8'd1;

    always_comb begin
        o_state  = i_state;
        ok_out   = 1'b0;
        out_dist = '0;
        if (!i_item.raw_ok) begin
            o_state.bad_count = bad_inc;
            if (i_state.initialized && (bad_inc < i_limit)) begin
                ok_out   = 1'b1;
                out_dist = i_state.filtered;
            end else if (bad_inc >= i_limit) begin
                o_state.filtered    = '0;
                o_state.initialized = 1'b0;
            end
        end else begin
            o_state.bad_count   = '0;
            o_state.initialized = 1'b1;
            o_state.filtered    = i_state.initialized ? blend : i_item.raw_distance;
            ok_out              = 1'b1;
            out_dist            = o_state.filtered;
        end

        // Unlisted codes and level zero both quantize directly
        o_state.level = ok_out ? next_level(i_state.level, out_dist) : LEVEL_0;

        o_result.smoothed_distance = out_dist;
        o_result.smoothed_ok       = ok_out;
        o_result.density           = o_state.level;
    end

endmodule

FILE: hdl/distance_filter_density_hysteresis.sv
// ============================================================================
// distance_filter_density_hysteresis
// Per-lane distance smoother with a six-level density quantizer.
// ============================================================================
// Takes one distance reading per transfer, one per clock cycle sustained
// while the output is not stalled. Each reading is read from the lane
// state memory in the cycle it is accepted, held in the update stage until
// the output register is free, updated there and written back as it moves
// into the output register, which offers its result until its transfer.
// Back-to-back readings of the same lane are served by forwarding the last
// write-back; no lane ever stalls the input. Lane state clears on reset via
// per-lane valid bits, without a clearing pass. Configuration (filter
// weight, invalid-reading limit) is taken at once and should be written
// only while the block holds no reading.
// ============================================================================
module distance_filter_density_hysteresis
    import dfdh_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ALPHA_W-1:0] r_alpha;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_s1_valid;
    t_in_item           r_s1_item;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               out_free;
    logic               s1_adv;
    logic               in_acc;
    logic               s1_in_range;
    t_lane_state        rd_state;
    t_lane_state        upd_state;
    t_out_item          upd_result;

    // Configuration registers: always ready, write decoded by index
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ALPHA_Q8:      r_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_INVALID_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: advance the update stage whenever the output register
    // is empty or being taken; accept a new reading whenever the update
    // stage can move on.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Lanes beyond the stored count change nothing and report all zero
    assign s1_in_range = 32'(r_s1_item.lane_index) < LANE_COUNT;

    dfdh_lane_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (LANE_AW'(i_in.lane_index)),
        .i_wr_en   (s1_adv && s1_in_range),
        .i_wr_addr (LANE_AW'(r_s1_item.lane_index)),
        .i_wr_data (upd_state),
        .o_rd_data (rd_state)
    );

    dfdh_update u_update (
        .i_state  (rd_state),
        .i_item   (r_s1_item),
        .i_alpha  (r_alpha),
        .i_limit  (r_limit),
        .o_state  (upd_state),
        .o_result (upd_result)
    );

    // Update stage: hold the item while its memory read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= i_in;
        end
    end

    // Output register: hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= s1_in_range ? upd_result : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!r_s1_valid || s1_adv))
        else $error("reading accepted while update stage blocked");

    a_density_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.density == LEVEL_0 || o_out.density == LEVEL_2 ||
                         o_out.density == LEVEL_4 || o_out.density == LEVEL_6 ||
                         o_out.density == LEVEL_8 || o_out.density == LEVEL_10))
        else $error("density outside the level set");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.smoothed_ok) |->
            (o_out.smoothed_distance == '0 && o_out.density == LEVEL_0))
        else $error("invalid result carries distance or level");

    a_alpha_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_ALPHA_Q8) |=>
            (r_alpha == $past(i_cfg_data[ALPHA_W-1:0])))
        else $error("filter weight write lost");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> o_out_valid)
        else $error("update stage advanced without a result");

endmodule
